// ===== src/window_switch_request_fsm_assert.svh =====
// Assertion macros for the window switch request machine.
// Included by the top level; depends on nothing else.
`ifndef WINDOW_SWITCH_REQUEST_FSM_ASSERT_SVH
`define WINDOW_SWITCH_REQUEST_FSM_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define WSR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("window switch request check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define WSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("window switch request check failed");

`endif

// ===== src/wsr_pkg.sv =====
// Shared types and codes for the window switch request machine.
// Depends on nothing; every other file but the assertion macro header imports it.
package wsr_pkg;

  localparam int unsigned SIG_W = 3;

  localparam logic [SIG_W-1:0] SIG_NONE        = 3'd0;
  localparam logic [SIG_W-1:0] SIG_AUTO_UP     = 3'd1;
  localparam logic [SIG_W-1:0] SIG_AUTO_DOWN   = 3'd2;
  localparam logic [SIG_W-1:0] SIG_MANUAL_UP   = 3'd3;
  localparam logic [SIG_W-1:0] SIG_MANUAL_DOWN = 3'd4;

  // Positions of the latched trigger flags, highest priority first.
  localparam int unsigned PEND_UP_BUTTON   = 0;
  localparam int unsigned PEND_DOWN_BUTTON = 1;
  localparam int unsigned PEND_SLIDE_UP    = 2;
  localparam int unsigned PEND_SLIDE_DOWN  = 3;
  localparam int unsigned PEND_W           = 4;

  typedef struct packed {
    logic up_button_trigger;
    logic down_button_trigger;
    logic slide_up_trigger;
    logic slide_down_trigger;
    logic long_press;
    logic up_button_held;
    logic down_button_held;
    logic slide_held;
  } wsr_item_t;

  // Contents of the input register as seen by the request logic.
  typedef struct packed {
    logic      valid;
    wsr_item_t item;
  } wsr_stage_t;

endpackage

// ===== src/wsr_ifs.sv =====
// Handshake channels for the window switch request machine.
// Depends on wsr_pkg for the request code width.
interface wsr_trig_if;
  logic valid;
  logic ready;
  logic up_button_trigger;
  logic down_button_trigger;
  logic slide_up_trigger;
  logic slide_down_trigger;
  logic long_press;
  logic up_button_held;
  logic down_button_held;
  logic slide_held;

  modport source (
    output valid, up_button_trigger, down_button_trigger, slide_up_trigger,
           slide_down_trigger, long_press, up_button_held, down_button_held,
           slide_held,
    input  ready
  );
  modport sink (
    input  valid, up_button_trigger, down_button_trigger, slide_up_trigger,
           slide_down_trigger, long_press, up_button_held, down_button_held,
           slide_held,
    output ready
  );
endinterface

interface wsr_result_if;
  import wsr_pkg::*;
  logic             valid;
  logic             ready;
  logic [SIG_W-1:0] request_signal;
  logic             report_valid;

  modport source (output valid, request_signal, report_valid, input ready);
  modport sink (input valid, request_signal, report_valid, output ready);
endinterface

// ===== src/wsr_in_reg.sv =====
// Input register of the window switch request machine.
// Depends on wsr_pkg and the wsr_trig_if channel.
module wsr_in_reg (
  input  logic                clk,
  input  logic                rst,
  wsr_trig_if.sink            trig,
  input  logic                take,
  output wsr_pkg::wsr_stage_t stage
);
  import wsr_pkg::*;

  // The register frees up in the same cycle that its contents are consumed.
  assign trig.ready = !stage.valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (trig.valid && trig.ready) begin
      stage.valid                    <= 1'b1;
      stage.item.up_button_trigger   <= trig.up_button_trigger;
      stage.item.down_button_trigger <= trig.down_button_trigger;
      stage.item.slide_up_trigger    <= trig.slide_up_trigger;
      stage.item.slide_down_trigger  <= trig.slide_down_trigger;
      stage.item.long_press          <= trig.long_press;
      stage.item.up_button_held      <= trig.up_button_held;
      stage.item.down_button_held    <= trig.down_button_held;
      stage.item.slide_held          <= trig.slide_held;
    end else if (take) begin
      stage.valid <= 1'b0;
    end
  end

endmodule

// ===== src/wsr_fsm.sv =====
// Request state machine and result register of the window switch request machine.
// Depends on wsr_pkg and the wsr_result_if channel.
module wsr_fsm (
  input  logic                clk,
  input  logic                rst,
  input  wsr_pkg::wsr_stage_t stage,
  output logic                take,
  wsr_result_if.source        result
);
  import wsr_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_BUTTON = 2'd1,
    MODE_SLIDE  = 2'd2
  } mode_t;

  mode_t             mode;
  mode_t             mode_next;
  logic [SIG_W-1:0]  cur_sig;
  logic [SIG_W-1:0]  cur_sig_next;
  logic [PEND_W-1:0] pending;
  logic [PEND_W-1:0] pending_next;
  logic              report;

  assign take = stage.valid && (!result.valid || result.ready);

  always_comb begin
    mode_next    = mode;
    cur_sig_next = cur_sig;
    report       = 1'b0;
    pending_next = pending;
    pending_next[PEND_UP_BUTTON]   = pending[PEND_UP_BUTTON]   | stage.item.up_button_trigger;
    pending_next[PEND_DOWN_BUTTON] = pending[PEND_DOWN_BUTTON] | stage.item.down_button_trigger;
    pending_next[PEND_SLIDE_UP]    = pending[PEND_SLIDE_UP]    | stage.item.slide_up_trigger;
    pending_next[PEND_SLIDE_DOWN]  = pending[PEND_SLIDE_DOWN]  | stage.item.slide_down_trigger;

    case (mode)
      MODE_IDLE: begin
        cur_sig_next = SIG_NONE;
        report       = |pending_next;
        if (pending_next[PEND_UP_BUTTON]) begin
          pending_next[PEND_UP_BUTTON] = 1'b0;
          cur_sig_next = stage.item.long_press ? SIG_MANUAL_UP : SIG_AUTO_UP;
          if (stage.item.long_press) mode_next = MODE_BUTTON;
        end else if (pending_next[PEND_DOWN_BUTTON]) begin
          pending_next[PEND_DOWN_BUTTON] = 1'b0;
          cur_sig_next = stage.item.long_press ? SIG_MANUAL_DOWN : SIG_AUTO_DOWN;
          if (stage.item.long_press) mode_next = MODE_BUTTON;
        end else if (pending_next[PEND_SLIDE_UP]) begin
          pending_next[PEND_SLIDE_UP] = 1'b0;
          cur_sig_next = stage.item.long_press ? SIG_MANUAL_UP : SIG_AUTO_UP;
          if (stage.item.long_press) mode_next = MODE_SLIDE;
        end else if (pending_next[PEND_SLIDE_DOWN]) begin
          pending_next[PEND_SLIDE_DOWN] = 1'b0;
          cur_sig_next = stage.item.long_press ? SIG_MANUAL_DOWN : SIG_AUTO_DOWN;
          if (stage.item.long_press) mode_next = MODE_SLIDE;
        end
      end
      MODE_BUTTON: begin
        // A button hold reports only while it carries a manual request.
        if (cur_sig == SIG_MANUAL_DOWN) begin
          report = 1'b1;
          if (!stage.item.down_button_held) mode_next = MODE_IDLE;
        end else if (cur_sig == SIG_MANUAL_UP) begin
          report = 1'b1;
          if (!stage.item.up_button_held) mode_next = MODE_IDLE;
        end
      end
      MODE_SLIDE: begin
        report = 1'b1;
        if (!stage.item.slide_held) mode_next = MODE_IDLE;
      end
      default: begin
        report = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      cur_sig      <= SIG_NONE;
      pending      <= '0;
      result.valid <= 1'b0;
    end else if (take) begin
      mode                  <= mode_next;
      cur_sig               <= cur_sig_next;
      pending               <= pending_next;
      result.valid          <= 1'b1;
      result.report_valid   <= report;
      result.request_signal <= report ? cur_sig_next : SIG_NONE;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

endmodule

// ===== src/window_switch_request_fsm.sv =====
// Top level of the window switch request machine.
// Depends on wsr_pkg, wsr_ifs, wsr_in_reg, wsr_fsm and the assertion macro header.

// The block turns touch-pad gestures into power-window requests, one tick per
// transaction on the trig channel and exactly one transaction on the result
// channel for each of them. Trigger pulses are latched as pending flags; in
// idle the highest-priority pending flag (button A, button B, slide up, slide
// down) is served, giving a manual request and a hold mode when long_press is
// set and a one-shot auto request otherwise. In a hold mode the manual request
// is reported every tick until the matching held level drops. When
// report_valid is low, request_signal reads as no request. Each transaction
// is captured in an input register at the edge that accepts it and its result
// is loaded into the result register once that register is free or being
// taken, so the input register and the result register lie between a
// transaction and its result. A new transaction is accepted every cycle while
// the result channel does not stall. A stalled result channel holds one result
// and one waiting input before trig.ready drops.
module window_switch_request_fsm (
  input logic          clk,
  input logic          rst,
  wsr_trig_if.sink     trig,
  wsr_result_if.source result
);
  import wsr_pkg::*;

`include "window_switch_request_fsm_assert.svh"

  wsr_stage_t stage;
  logic       take;

  wsr_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .trig  (trig),
    .take  (take),
    .stage (stage)
  );

  wsr_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .stage  (stage),
    .take   (take),
    .result (result)
  );

  // A result that is not reported must carry no request.
  `WSR_ASSERT_SAME(a_quiet_result, clk, rst,
    result.valid && !result.report_valid,
    result.request_signal == SIG_NONE)
  // A reported result always carries a real request code.
  `WSR_ASSERT_SAME(a_reported_code, clk, rst,
    result.valid && result.report_valid,
    result.request_signal != SIG_NONE && result.request_signal <= SIG_MANUAL_DOWN)
  // With the input register full and the result stalled, nothing more may enter.
  `WSR_ASSERT_SAME(a_backpressure, clk, rst,
    stage.valid && result.valid && !result.ready, !trig.ready)
  // An accepted transaction is always waiting in the input register next cycle.
  `WSR_ASSERT_NEXT(a_capture, clk, rst, trig.valid && trig.ready, stage.valid)

endmodule

// ===== dv/tb_window_switch_request_fsm.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the window switch request machine.
// Depends on wsr_pkg, the wsr_trig_if and wsr_result_if channels and the block's top level.

module tb_window_switch_request_fsm;
  import wsr_pkg::*;

  // Time allowed with no transaction on either channel before the run is
  // abandoned. The longest legitimate quiet stretch is the receiver hold-off
  // below, so this is many times over.
  localparam int unsigned QUIET_LIMIT    = 1000;
  localparam int unsigned TOTAL_ITEMS    = 1400;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned HOLD_OFF_TICKS = 48;
  // The drain at the end catches any stray result.
  localparam int unsigned DRAIN_TICKS    = 8;

  // The predictor keeps its own copy of the hold mode.
  typedef enum logic [1:0] {
    HOLD_IDLE   = 2'd0,
    HOLD_BUTTON = 2'd1,
    HOLD_SLIDE  = 2'd2
  } hold_mode_t;

  typedef struct packed {
    logic [SIG_W-1:0] request_signal;
    logic             report_valid;
  } request_t;

  // Predicts the request for every accepted gesture tick and compares each
  // result transaction with the oldest prediction still awaited.
  class window_request_tracker;
    hold_mode_t        mode;
    logic [SIG_W-1:0]  held_signal;
    logic [PEND_W-1:0] latched;
    request_t          awaited[$];
    int unsigned       failures;

    function new();
      mode        = HOLD_IDLE;
      held_signal = SIG_NONE;
      latched     = '0;
      failures    = 0;
    endfunction

    function void note_gesture(wsr_item_t g);
      request_t          r;
      logic [PEND_W-1:0] pick;
      logic              upward;
      hold_mode_t        target;
      r      = '0;
      pick   = '0;
      upward = 1'b0;
      target = HOLD_IDLE;
      // Trigger pulses are latched before the step is taken.
      latched[PEND_UP_BUTTON]   |= g.up_button_trigger;
      latched[PEND_DOWN_BUTTON] |= g.down_button_trigger;
      latched[PEND_SLIDE_UP]    |= g.slide_up_trigger;
      latched[PEND_SLIDE_DOWN]  |= g.slide_down_trigger;
      case (mode)
        HOLD_IDLE: begin
          held_signal = SIG_NONE;
          if (latched[PEND_UP_BUTTON]) begin
            pick[PEND_UP_BUTTON] = 1'b1;
            upward = 1'b1;
            target = HOLD_BUTTON;
          end else if (latched[PEND_DOWN_BUTTON]) begin
            pick[PEND_DOWN_BUTTON] = 1'b1;
            target = HOLD_BUTTON;
          end else if (latched[PEND_SLIDE_UP]) begin
            pick[PEND_SLIDE_UP] = 1'b1;
            upward = 1'b1;
            target = HOLD_SLIDE;
          end else if (latched[PEND_SLIDE_DOWN]) begin
            pick[PEND_SLIDE_DOWN] = 1'b1;
            target = HOLD_SLIDE;
          end
          if (pick != '0) begin
            latched &= ~pick;
            if (g.long_press) begin
              held_signal = upward ? SIG_MANUAL_UP : SIG_MANUAL_DOWN;
              mode = target;
            end else begin
              held_signal = upward ? SIG_AUTO_UP : SIG_AUTO_DOWN;
            end
            r.report_valid = 1'b1;
          end
        end
        HOLD_BUTTON: begin
          if (held_signal == SIG_MANUAL_DOWN) begin
            r.report_valid = 1'b1;
            if (!g.down_button_held) mode = HOLD_IDLE;
          end else if (held_signal == SIG_MANUAL_UP) begin
            r.report_valid = 1'b1;
            if (!g.up_button_held) mode = HOLD_IDLE;
          end
        end
        HOLD_SLIDE: begin
          r.report_valid = 1'b1;
          if (!g.slide_held) mode = HOLD_IDLE;
        end
        default: ;
      endcase
      r.request_signal = r.report_valid ? held_signal : SIG_NONE;
      awaited.push_back(r);
    endfunction

    function void check_request(logic [SIG_W-1:0] sig, logic rv);
      request_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: request_signal %0d report_valid %0b", sig, rv);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (sig !== want.request_signal) begin
        $error("request_signal: expected %0d, actual %0d", want.request_signal, sig);
        failures++;
      end
      if (rv !== want.report_valid) begin
        $error("report_valid: expected %0b, actual %0b", want.report_valid, rv);
        failures++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  wsr_trig_if   trig ();
  wsr_result_if result ();

  window_switch_request_fsm dut (
    .clk    (clk),
    .rst    (rst),
    .trig   (trig),
    .result (result)
  );

  window_request_tracker tracker = new();

  // Shared between the stimulus, the two channel drivers, the monitor and the watchdog.
  int unsigned sent_count  = 0;
  int unsigned burst_left  = 0;
  bit          gaps_on     = 1'b1;
  int unsigned ready_style = 1;
  bit          hold_off_due = 1'b0;
  int unsigned quiet_ticks = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offers one gesture tick and returns at the edge where it is accepted.
  // The sender works in bursts; between bursts valid drops
  // unless gaps are switched off for the current phase.
  task automatic send_gesture(input wsr_item_t g);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        trig.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    trig.valid               <= 1'b1;
    trig.up_button_trigger   <= g.up_button_trigger;
    trig.down_button_trigger <= g.down_button_trigger;
    trig.slide_up_trigger    <= g.slide_up_trigger;
    trig.slide_down_trigger  <= g.slide_down_trigger;
    trig.long_press          <= g.long_press;
    trig.up_button_held      <= g.up_button_held;
    trig.down_button_held    <= g.down_button_held;
    trig.slide_held          <= g.slide_held;
    do @(posedge clk); while (!trig.ready);
    sent_count++;
  endtask

  // Mostly a well-formed gesture: a trigger, then for a long press a run of
  // ticks with the matching level held and a tick that releases it. Stray
  // triggers and levels ride along as noise, and now and then a wholly random
  // tick or a quiet tick is thrown in.
  task automatic random_gesture();
    wsr_item_t   g;
    int unsigned kind;
    int unsigned ticks;
    int unsigned k;
    if ($urandom_range(0, 6) == 0) begin
      g = wsr_item_t'($urandom);
      send_gesture(g);
      return;
    end
    kind = $urandom_range(0, 3);
    g = wsr_item_t'($urandom);
    if ($urandom_range(0, 7) != 0) begin
      g.up_button_trigger   = 1'b0;
      g.down_button_trigger = 1'b0;
      g.slide_up_trigger    = 1'b0;
      g.slide_down_trigger  = 1'b0;
    end
    case (kind)
      0: g.up_button_trigger   = 1'b1;
      1: g.down_button_trigger = 1'b1;
      2: g.slide_up_trigger    = 1'b1;
      default: g.slide_down_trigger = 1'b1;
    endcase
    send_gesture(g);
    if (g.long_press) begin
      ticks = $urandom_range(0, 6);
      for (k = 0; k <= ticks; k++) begin
        g = wsr_item_t'($urandom);
        if ($urandom_range(0, 5) != 0) begin
          g.up_button_trigger   = 1'b0;
          g.down_button_trigger = 1'b0;
          g.slide_up_trigger    = 1'b0;
          g.slide_down_trigger  = 1'b0;
        end
        // The last of these ticks lets go of the gesture.
        case (kind)
          0: g.up_button_held   = (k != ticks);
          1: g.down_button_held = (k != ticks);
          default: g.slide_held = (k != ticks);
        endcase
        send_gesture(g);
      end
    end
    if ($urandom_range(0, 3) == 0) send_gesture('0);
  endtask

  // Result side: stalls follow a style chosen per phase, and on request the
  // receiver holds off for a long stretch so that the block fills up and
  // pushes back on the trig channel.
  initial begin : receiver
    int unsigned beat;
    beat = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      beat++;
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        result.ready <= 1'b0;
        repeat (HOLD_OFF_TICKS) @(posedge clk);
      end else begin
        case (ready_style)
          0: result.ready <= 1'b1;
          1: result.ready <= ($urandom_range(0, 3) != 0);
          default: result.ready <= ((beat % 7) >= 3);
        endcase
      end
    end
  end

  // Both channels are sampled at the rising edge, before the values driven at
  // that edge take effect.
  always @(posedge clk) begin
    wsr_item_t seen;
    logic      moved;
    moved = 1'b0;
    if (!rst) begin
      if (trig.valid && trig.ready) begin
        seen.up_button_trigger   = trig.up_button_trigger;
        seen.down_button_trigger = trig.down_button_trigger;
        seen.slide_up_trigger    = trig.slide_up_trigger;
        seen.slide_down_trigger  = trig.slide_down_trigger;
        seen.long_press          = trig.long_press;
        seen.up_button_held      = trig.up_button_held;
        seen.down_button_held    = trig.down_button_held;
        seen.slide_held          = trig.slide_held;
        tracker.note_gesture(seen);
        moved = 1'b1;
      end
      if (result.valid && result.ready) begin
        tracker.check_request(result.request_signal, result.report_valid);
        moved = 1'b1;
      end
    end
    quiet_ticks <= moved ? 0 : quiet_ticks + 1;
  end

  initial begin : watchdog
    while (quiet_ticks < QUIET_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned next_phase;
    int unsigned phase_idx;
    next_phase = 0;
    phase_idx  = 0;
    rst                      <= 1'b1;
    trig.valid               <= 1'b0;
    trig.up_button_trigger   <= 1'b0;
    trig.down_button_trigger <= 1'b0;
    trig.slide_up_trigger    <= 1'b0;
    trig.slide_down_trigger  <= 1'b0;
    trig.long_press          <= 1'b0;
    trig.up_button_held      <= 1'b0;
    trig.down_button_held    <= 1'b0;
    trig.slide_held          <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks. Bit layout, high to low: button A, button B, slide up
    // and slide down triggers, then long press, button A held, button B held
    // and slide held.
    send_gesture(8'b0000_0000);  // idle with nothing pending
    send_gesture(8'b1000_0000);  // each trigger alone gives an auto request
    send_gesture(8'b0100_0000);
    send_gesture(8'b0010_0000);
    send_gesture(8'b0001_0000);
    send_gesture(8'b1111_0000);  // all at once: served in priority order
    send_gesture(8'b0000_0000);
    send_gesture(8'b0000_0000);
    send_gesture(8'b0000_0000);
    send_gesture(8'b1000_1100);  // long press on button A enters button hold
    send_gesture(8'b0111_0100);  // triggers during the hold stay latched
    send_gesture(8'b0000_0111);
    send_gesture(8'b0000_0011);  // button A let go: back to idle
    send_gesture(8'b0000_1010);  // latched button B served as manual down
    send_gesture(8'b0000_0110);
    send_gesture(8'b0000_0101);
    send_gesture(8'b0000_1001);  // latched slide up enters slide hold
    send_gesture(8'b0000_0001);
    send_gesture(8'b0000_0000);
    send_gesture(8'b0000_1000);  // latched slide down, manual, released at once
    send_gesture(8'b0000_0000);
    send_gesture(8'b1111_1111);  // every bit set
    send_gesture(8'b0000_0000);
    send_gesture(8'b0000_0000);
    send_gesture(8'b0000_0000);

    // Random phases, each with its own sender and receiver behaviour. Every
    // third phase the sender runs without gaps while the receiver holds off.
    while (sent_count < TOTAL_ITEMS) begin
      if (sent_count >= next_phase) begin
        next_phase  = sent_count + PHASE_ITEMS;
        gaps_on     = ($urandom_range(0, 1) != 0);
        ready_style = $urandom_range(0, 2);
        if (phase_idx % 3 == 1) begin
          gaps_on      = 1'b0;
          hold_off_due = 1'b1;
        end
        phase_idx++;
      end
      random_gesture();
    end
    trig.valid <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/wsr_pkg.sv
src/wsr_ifs.sv
src/wsr_in_reg.sv
src/wsr_fsm.sv
src/window_switch_request_fsm.sv
dv/tb_window_switch_request_fsm.sv
